### rtl/segmented_length_code_decoder_defines.svh
// Assertion macros shared by the segmented length code decoder RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SEGMENTED_LENGTH_CODE_DECODER_DEFINES_SVH
`define SEGMENTED_LENGTH_CODE_DECODER_DEFINES_SVH

// Same-cycle implication.
`define SLCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slcd assertion failed");

// Next-cycle implication.
`define SLCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slcd assertion failed");

`endif

### rtl/slcd_pkg.sv
// Types and constants for the segmented length code decoder.
// No dependencies.
package slcd_pkg;

	localparam int MAX_CODE_BITS = 7;
	localparam int TABLE_DEPTH   = 256;
	localparam int ADDR_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_W        = 8;
	localparam int ACC_W         = 7;
	localparam int LEN_W         = 3;
	localparam int FLAT_W        = 9;

	localparam int CAP_RAW   = (1 << (MAX_CODE_BITS + 1)) - MAX_CODE_BITS - 2;
	localparam int CAP_DEPTH = (CAP_RAW > TABLE_DEPTH) ? TABLE_DEPTH : CAP_RAW;
	localparam int TABLE_CAP = (CAP_DEPTH > 255) ? 255 : CAP_DEPTH;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic       KIND_HEADER  = 1'b0;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload;
	} item_t;

	typedef struct packed {
		logic [7:0] decoded_char;
		logic       message_end;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              emit;
		logic              msg_end;
		logic              filled;
	} tbl_req_t;

endpackage

### rtl/slcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/slcd_ctrl.sv
// Bit-stream parser: header fill count, phase, field accumulator and table requests.
// Depends on slcd_pkg and the assertion macros.
`include "segmented_length_code_decoder_defines.svh"
module slcd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  slcd_pkg::item_t  item,
	output slcd_pkg::tbl_req_t req
);
	import slcd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_CODES  = 2'd2
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [ACC_W-1:0]   acc_q, acc_d, acc_base, acc_new;
	logic [LEN_W-1:0]   taken_q, taken_d, taken_base, taken_new;
	logic [LEN_W-1:0]   seglen_q, seglen_d;
	logic [ACC_W-1:0]   code_mask, code_val;
	logic [FLAT_W-1:0]  flat;
	logic               is_header;
	logic               is_codes;

	always_comb begin
		is_header = (phase_q != PH_LENGTH) && (phase_q != PH_CODES);
		is_codes  = (phase_q == PH_CODES);
		acc_base   = is_header ? '0 : acc_q;
		taken_base = is_header ? '0 : taken_q;
		acc_new    = {acc_base[ACC_W-2:0], item.payload[0]};
		taken_new  = taken_base + LEN_W'(1);
		code_mask  = ACC_W'((8'd1 << seglen_q) - 8'd1);
		code_val   = acc_new & code_mask;
		flat       = (FLAT_W'(1) << seglen_q) - FLAT_W'(seglen_q) - FLAT_W'(1)
			+ FLAT_W'(code_val);

		phase_d  = phase_q;
		fill_d   = fill_q;
		acc_d    = acc_q;
		taken_d  = taken_q;
		seglen_d = seglen_q;
		req      = '0;
		req.wr_addr = fill_q[ADDR_W-1:0];
		req.wr_data = item.payload;
		req.rd_addr = flat[ADDR_W-1:0];
		req.filled  = (flat < FLAT_W'(fill_q)) && (flat < FLAT_W'(TABLE_DEPTH));

		if (item.kind == KIND_HEADER) begin
			if (is_header) begin
				phase_d = PH_HEADER;
				if (fill_q < FILL_W'(TABLE_CAP)) begin
					req.wr_en = 1'b1;
					fill_d    = fill_q + FILL_W'(1);
				end
			end
		end else if (!is_codes) begin
			if (taken_new == LEN_W'(3)) begin
				acc_d   = '0;
				taken_d = '0;
				if (acc_new[LEN_W-1:0] == '0) begin
					fill_d      = '0;
					seglen_d    = '0;
					phase_d     = PH_HEADER;
					req.emit    = 1'b1;
					req.msg_end = 1'b1;
				end else begin
					seglen_d = acc_new[LEN_W-1:0];
					phase_d  = PH_CODES;
				end
			end else begin
				acc_d   = acc_new;
				taken_d = taken_new;
				phase_d = PH_LENGTH;
			end
		end else begin
			if (taken_new == seglen_q) begin
				acc_d   = '0;
				taken_d = '0;
				if (code_val == code_mask) begin
					phase_d = PH_LENGTH;
				end else begin
					req.emit  = 1'b1;
					req.rd_en = 1'b1;
				end
			end else begin
				acc_d   = acc_new;
				taken_d = taken_new;
			end
		end

		req.wr_en = req.wr_en & accept;
		req.rd_en = req.rd_en & accept;
		req.emit  = req.emit & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			fill_q   <= '0;
			acc_q    <= '0;
			taken_q  <= '0;
			seglen_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			fill_q   <= fill_d;
			acc_q    <= acc_d;
			taken_q  <= taken_d;
			seglen_q <= seglen_d;
		end
	end

	`SLCD_ASSERT_NOW(a_rd_in_codes, req.rd_en, phase_q == PH_CODES)
	`SLCD_ASSERT_NOW(a_fill_cap, 1'b1, fill_q <= FILL_W'(TABLE_CAP))
	`SLCD_ASSERT_NOW(a_seglen_codes, phase_q == PH_CODES, seglen_q != '0)

endmodule

### rtl/segmented_length_code_decoder.sv
// Top level of the segmented length code decoder: parser, code table RAM, result stages.
// Depends on slcd_pkg, slcd_ctrl, slcd_ram and the assertion macros.
//
// Usage:
//   item channel (item_valid/item_ready/item): kind 0 carries a header character
//   that fills the code table in order; kind 1 carries one message bit in payload[0].
//   result channel (result_valid/result_ready/result): one beat per decoded code,
//   plus a newline beat with message_end set when a zero segment length closes
//   the message; the next header character then starts a fresh table.
// Throughput: one item beat per cycle while item_ready is high, limited by the single
//   table read port (one read per completed code) and the per-bit parser update.
// Result path: the item beat that completes a code starts the registered table
//   read, and the result then passes through the result register to the output.
// Stall: while result_ready is low the result register holds; one more result
//   waits in the read stage, after which item_ready drops until the receiver drains.
// Reset: arst_n clears the phase, fill count, field accumulator and all valid
//   flags; the table RAM is not cleared, entries beyond the fill count read as 0.
`include "segmented_length_code_decoder_defines.svh"
module segmented_length_code_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  slcd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output slcd_pkg::result_t result
);
	import slcd_pkg::*;

	tbl_req_t   req;
	logic       accept;
	logic       s1_move;
	logic       valid_s1;
	logic       end_s1;
	logic       filled_s1;
	logic [7:0] rd_data;
	logic       out_valid_q;
	result_t    out_q;
	result_t    s1_result;

	assign s1_move    = !out_valid_q || result_ready;
	assign item_ready = !valid_s1 || s1_move;
	assign accept     = item_valid && item_ready;

	slcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.req    (req)
	);

	slcd_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata (req.wr_data),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		s1_result.message_end  = end_s1;
		s1_result.decoded_char = end_s1 ? NEWLINE_CHAR : (filled_s1 ? rd_data : 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= req.emit;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && req.emit) begin
			end_s1    <= req.msg_end;
			filled_s1 <= req.filled;
		end
		if (s1_move && valid_s1) begin
			out_q <= s1_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`SLCD_ASSERT_NOW(a_ready_stall, !item_ready, valid_s1 && out_valid_q && !result_ready)
	`SLCD_ASSERT_NOW(a_one_port, req.wr_en, !req.rd_en)
	`SLCD_ASSERT_NEXT(a_end_staged, req.emit && req.msg_end, valid_s1 && end_s1)

endmodule

### tb/sv/tb_segmented_length_code_decoder.sv
// Self-checking testbench for segmented_length_code_decoder: drives header and message-bit
// beats with random idling and checks every decoded character against an in-bench decoder.
// Depends on slcd_pkg and the segmented_length_code_decoder RTL.
module tb_segmented_length_code_decoder;
	import slcd_pkg::*;

	localparam logic KIND_BIT     = 1'b1;
	localparam int   CHAR_SLOTS   = (1 << (MAX_CODE_BITS + 1)) - MAX_CODE_BITS - 2;
	localparam int   CYCLE_LIMIT  = 300000;
	localparam int   RANDOM_BEATS = 240;

	typedef enum logic [1:0] {
		PARSE_HEADER,
		PARSE_LENGTH,
		PARSE_CODES
	} parse_state_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	logic [7:0]   char_table [CHAR_SLOTS];
	int unsigned  chars_loaded;
	parse_state_t parse_state;
	logic [6:0]   field_bits;
	logic [2:0]   field_count;
	logic [2:0]   code_len;
	result_t      expected_chars [$];

	int unsigned useful_beats;
	int unsigned mismatches;
	int          send_gap_max;
	int          sink_gap_max;
	int          sink_hold;
	bit          beat_taken;

	segmented_length_code_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void decode_beat(input item_t beat);
		int unsigned all_ones;
		int unsigned code;
		int unsigned flat;
		result_t     out;
		if (beat.kind == KIND_HEADER) begin
			if (parse_state == PARSE_HEADER && chars_loaded < CHAR_SLOTS) begin
				char_table[chars_loaded] = beat.payload;
				chars_loaded++;
				useful_beats++;
			end
			return;
		end
		useful_beats++;
		if (parse_state == PARSE_HEADER) begin
			parse_state = PARSE_LENGTH;
			field_bits = '0;
			field_count = '0;
		end
		field_bits = {field_bits[5:0], beat.payload[0]};
		field_count = field_count + 3'd1;
		if (parse_state == PARSE_LENGTH) begin
			if (field_count == 3'd3) begin
				code_len = field_bits[2:0];
				field_bits = '0;
				field_count = '0;
				if (code_len == 3'd0) begin
					chars_loaded = 0;
					parse_state = PARSE_HEADER;
					out.decoded_char = NEWLINE_CHAR;
					out.message_end = 1'b1;
					expected_chars.push_back(out);
				end else begin
					parse_state = PARSE_CODES;
				end
			end
			return;
		end
		if (field_count == code_len) begin
			all_ones = (1 << code_len) - 1;
			code = field_bits & all_ones;
			field_bits = '0;
			field_count = '0;
			if (code == all_ones) begin
				parse_state = PARSE_LENGTH;
				return;
			end
			flat = all_ones - code_len + code;
			out.decoded_char = (flat < chars_loaded) ? char_table[flat] : 8'd0;
			out.message_end = 1'b0;
			expected_chars.push_back(out);
		end
	endfunction

	task automatic send_item(input logic kind, input logic [7:0] payload);
		int    gap;
		item_t beat;
		beat.kind = kind;
		beat.payload = payload;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (!item_ready);
		decode_beat(beat);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	task automatic send_bits(input int unsigned value, input int width);
		for (int i = width - 1; i >= 0; i--)
			send_item(KIND_BIT, {7'($urandom), value[i]});
	endtask

	task automatic load_table(input int count);
		repeat (count) send_item(KIND_HEADER, 8'($urandom));
	endtask

	task automatic send_segment(input int len);
		send_bits(len, 3);
		repeat ($urandom_range(0, 6)) send_bits($urandom_range(0, (1 << len) - 2), len);
		send_bits((1 << len) - 1, len);
	endtask

	task automatic test_short_codes();
		send_item(KIND_HEADER, 8'h00);
		send_item(KIND_HEADER, 8'hFF);
		send_item(KIND_HEADER, 8'h41);
		send_bits(1, 3);
		send_bits(0, 1);
		send_bits(1, 1);
		send_bits(2, 3);
		send_bits(0, 2);
		send_bits(1, 2);
		send_bits(2, 2);
		send_item(KIND_HEADER, 8'h5A);
		send_bits(3, 2);
		send_bits(7, 3);
		send_bits(0, 7);
		send_bits(127, 7);
		send_bits(3, 3);
		send_bits(6, 3);
		send_bits(7, 3);
		send_bits(0, 3);
	endtask

	task automatic test_empty_table();
		send_bits(1, 3);
		send_bits(0, 1);
		send_bits(1, 1);
		send_bits(0, 3);
		send_bits(0, 3);
	endtask

	task automatic test_full_table();
		load_table(CHAR_SLOTS + 5);
		send_bits(7, 3);
		send_bits(0, 7);
		send_bits(126, 7);
		send_bits(127, 7);
		send_bits(1, 3);
		send_bits(0, 1);
		send_bits(1, 1);
		send_bits(0, 3);
		send_item(KIND_HEADER, 8'h78);
		send_bits(1, 3);
		send_bits(0, 1);
		send_bits(1, 1);
		send_bits(0, 3);
	endtask

	task automatic test_backpressure();
		send_gap_max = 0;
		load_table(2);
		sink_hold = 150;
		send_bits(1, 3);
		repeat (40) send_bits($urandom_range(0, 0), 1);
		wait_drained();
		repeat (10) send_bits(0, 1);
		send_bits(1, 1);
		send_bits(0, 3);
		send_gap_max = 3;
	endtask

	task automatic test_random_messages();
		int unsigned goal;
		goal = useful_beats + RANDOM_BEATS;
		while (useful_beats < goal) begin
			send_gap_max = $urandom_range(0, 1) ? 3 : 0;
			sink_gap_max = $urandom_range(0, 1) ? 3 : 0;
			if ($urandom_range(0, 11) == 0)
				load_table($urandom_range(CHAR_SLOTS - 6, CHAR_SLOTS + 5));
			else
				load_table($urandom_range(0, 24));
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 9))
					0: send_item(KIND_HEADER, 8'($urandom));
					1: send_bits($urandom, $urandom_range(1, 5));
					default: send_segment($urandom_range(1, MAX_CODE_BITS));
				endcase
				if ($urandom_range(0, 7) == 0)
					wait_drained();
			end
			send_bits(0, 3);
		end
	endtask

	initial begin : result_sink
		int sink_stall;
		sink_stall = 0;
		result_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (beat_taken) begin
				beat_taken = 1'b0;
				sink_stall = $urandom_range(0, sink_gap_max);
			end
			if (sink_hold > 0) begin
				sink_hold--;
				result_ready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				beat_taken = 1'b1;
				if (expected_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: char %02h end %0b",
							result.decoded_char, result.message_end);
				end else begin
					want = expected_chars.pop_front();
					if (result.decoded_char !== want.decoded_char
						|| result.message_end !== want.message_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected char %02h end %0b, got char %02h end %0b",
								want.decoded_char, want.message_end,
								result.decoded_char, result.message_end);
					end
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle;
		for (cycle = 0; cycle < CYCLE_LIMIT; cycle++)
			@(posedge clk);
		$display("tb_segmented_length_code_decoder: errors");
		$finish;
	end

	initial begin
		chars_loaded = 0;
		parse_state = PARSE_HEADER;
		field_bits = '0;
		field_count = '0;
		code_len = '0;
		useful_beats = 0;
		mismatches = 0;
		send_gap_max = 3;
		sink_gap_max = 3;
		sink_hold = 0;
		beat_taken = 1'b0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_short_codes();
		test_empty_table();
		test_full_table();
		test_backpressure();
		test_random_messages();
		wait_drained();
		repeat (8) @(posedge clk);
		mismatches += expected_chars.size();
		if (mismatches == 0) begin
			$display("tb_segmented_length_code_decoder: clean");
		end else begin
			$display("tb_segmented_length_code_decoder: errors");
		end
		$finish;
	end

endmodule

### segmented_length_code_decoder.f
+incdir+rtl
rtl/slcd_pkg.sv
rtl/slcd_ram.sv
rtl/slcd_ctrl.sv
rtl/segmented_length_code_decoder.sv
tb/sv/tb_segmented_length_code_decoder.sv
